[rtl/core/cfr_pkg.sv]
// Package for the command frame receiver: frame constants, receive phase,
// action and result codes, and the structs passed between the modules.
// Depends on nothing.
`timescale 1ns / 1ps

package cfr_pkg;

   // Payload bytes at this index and above are counted but not reported.
   localparam logic [7:0] PAYLOAD_CAPACITY = 8'd128;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hAA;
   localparam int         HAS_PAYLOAD_BIT = 7;

   // Configuration register indexes (byte address is four times the index).
   localparam int          CSR_ADDR_WIDTH = 4;
   localparam logic [1:0]  REG_CHECKSUM_ENABLE = 2'd0;
   localparam logic [1:0]  REG_CHECKSUM_SEED = 2'd1;
   localparam logic [1:0]  REG_TIMEOUT_TICKS = 2'd2;

   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_ID   = 3'd1,
      PH_LEN  = 3'd2,
      PH_DATA = 3'd3,
      PH_SUM  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ACT_BYTE  = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_FLUSH = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      KIND_PAYLOAD   = 3'd0,
      KIND_FRAME_OK  = 3'd1,
      KIND_CHECKSUM  = 3'd2,
      KIND_FRAME_OVF = 3'd3,
      KIND_TIMEOUT   = 3'd4,
      KIND_INPUT_OVF = 3'd5
   } kind_type;

   typedef struct packed {
      logic        checksum_enable;
      logic [7:0]  checksum_seed;
      logic [15:0] timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [6:0] command_id;
      logic [7:0] payload_length;
      logic [7:0] byte_index;
      logic [7:0] data_byte;
   } result_type;

endpackage

[rtl/core/cfr_csr.sv]
// Configuration registers of the command frame receiver behind an APB-style port.
// Depends on cfr_pkg for the register indexes and the configuration struct.
`timescale 1ns / 1ps

module cfr_csr
   import cfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output cfg_type                   cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       write_en;
   logic [1:0] reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_CHECKSUM_ENABLE: cfg_in.checksum_enable = csr_pwdata[0];
            REG_CHECKSUM_SEED:   cfg_in.checksum_seed   = csr_pwdata[7:0];
            REG_TIMEOUT_TICKS:   cfg_in.timeout_ticks   = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CHECKSUM_ENABLE: csr_prdata = {31'd0, cfg_ff.checksum_enable};
         REG_CHECKSUM_SEED:   csr_prdata = {24'd0, cfg_ff.checksum_seed};
         REG_TIMEOUT_TICKS:   csr_prdata = {16'd0, cfg_ff.timeout_ticks};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.checksum_enable <= 1'b0;
         cfg_ff.checksum_seed   <= 8'd0;
         cfg_ff.timeout_ticks   <= TIMEOUT_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/cfr_engine.sv]
// Frame state of the command frame receiver: phase, frame fields, running sum
// and inactivity countdown, advanced once per request. Depends on cfr_pkg.
`timescale 1ns / 1ps

module cfr_engine
   import cfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [1:0] action,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output result_type result
);

   phase_type   phase_ff, phase_in;
   logic [6:0]  frame_id_ff, frame_id_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  bytes_received_ff, bytes_received_in;
   logic        overflowed_ff, overflowed_in;
   logic [7:0]  running_sum_ff, running_sum_in;
   logic [15:0] idle_countdown_ff, idle_countdown_in;

   logic [7:0]  next_count;
   logic        over_capacity;
   logic        has_payload;

   assign next_count    = bytes_received_ff + 8'd1;
   assign over_capacity = (bytes_received_ff >= PAYLOAD_CAPACITY);
   assign has_payload   = rx_byte[HAS_PAYLOAD_BIT];

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (action_type'(action))
         ACT_TICK: begin
            if (idle_countdown_ff == 16'd1) begin
               phase_in = PH_WAIT;
            end
         end
         ACT_FLUSH: phase_in = PH_WAIT;
         ACT_BYTE: begin
            case (phase_ff)
               PH_ID:   phase_in = has_payload ? PH_LEN : PH_SUM;
               PH_LEN:  phase_in = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
               PH_DATA: begin
                  if (next_count == frame_length_ff) begin
                     phase_in = PH_SUM;
                  end
               end
               PH_SUM:  phase_in = PH_WAIT;
               default: phase_in = (rx_byte == PREAMBLE_BYTE) ? PH_ID : PH_WAIT;
            endcase
         end
         default: phase_in = phase_ff;
      endcase
   end

   // Frame fields, counters and the result.
   always_comb begin
      frame_id_in       = frame_id_ff;
      frame_length_in   = frame_length_ff;
      bytes_received_in = bytes_received_ff;
      overflowed_in     = overflowed_ff;
      running_sum_in    = running_sum_ff;
      idle_countdown_in = idle_countdown_ff;
      result            = '0;
      result.kind       = KIND_PAYLOAD;

      case (action_type'(action))
         ACT_TICK: begin
            if (idle_countdown_ff != 16'd0) begin
               idle_countdown_in = idle_countdown_ff - 16'd1;
               if (idle_countdown_ff == 16'd1) begin
                  overflowed_in = 1'b0;
                  result.valid  = 1'b1;
                  result.kind   = KIND_TIMEOUT;
               end
            end
         end
         ACT_FLUSH: begin
            overflowed_in     = 1'b0;
            bytes_received_in = 8'd0;
            idle_countdown_in = 16'd0;
            result.valid      = 1'b1;
            result.kind       = KIND_INPUT_OVF;
         end
         ACT_BYTE: begin
            case (phase_ff)
               PH_ID: begin
                  running_sum_in    = running_sum_ff + rx_byte;
                  idle_countdown_in = cfg.timeout_ticks;
                  frame_id_in       = rx_byte[6:0];
               end
               PH_LEN: begin
                  running_sum_in    = running_sum_ff + rx_byte;
                  idle_countdown_in = cfg.timeout_ticks;
                  frame_length_in   = rx_byte;
               end
               PH_DATA: begin
                  idle_countdown_in = cfg.timeout_ticks;
                  bytes_received_in = next_count;
                  if (over_capacity) begin
                     overflowed_in = 1'b1;
                  end else begin
                     running_sum_in    = running_sum_ff + rx_byte;
                     result.valid      = 1'b1;
                     result.kind       = KIND_PAYLOAD;
                     result.byte_index = bytes_received_ff;
                     result.data_byte  = rx_byte;
                  end
               end
               PH_SUM: begin
                  idle_countdown_in = 16'd0;
                  result.valid      = 1'b1;
                  if (overflowed_ff) begin
                     overflowed_in = 1'b0;
                     result.kind   = KIND_FRAME_OVF;
                  end else if (cfg.checksum_enable && (running_sum_ff != rx_byte)) begin
                     result.kind = KIND_CHECKSUM;
                  end else begin
                     result.kind = KIND_FRAME_OK;
                  end
               end
               default: begin
                  idle_countdown_in = 16'd0;
                  if (rx_byte == PREAMBLE_BYTE) begin
                     frame_length_in   = 8'd0;
                     bytes_received_in = 8'd0;
                     overflowed_in     = 1'b0;
                     running_sum_in    = cfg.checksum_seed + PREAMBLE_BYTE;
                     idle_countdown_in = cfg.timeout_ticks;
                  end
               end
            endcase
         end
         default: result.valid = 1'b0;
      endcase

      // Identifier and length are reported as they stand after this request.
      result.command_id     = frame_id_in;
      result.payload_length = frame_length_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_WAIT;
         frame_id_ff       <= 7'd0;
         frame_length_ff   <= 8'd0;
         bytes_received_ff <= 8'd0;
         overflowed_ff     <= 1'b0;
         running_sum_ff    <= 8'd0;
         idle_countdown_ff <= 16'd0;
      end else if (step) begin
         phase_ff          <= phase_in;
         frame_id_ff       <= frame_id_in;
         frame_length_ff   <= frame_length_in;
         bytes_received_ff <= bytes_received_in;
         overflowed_ff     <= overflowed_in;
         running_sum_ff    <= running_sum_in;
         idle_countdown_ff <= idle_countdown_in;
      end
   end

endmodule

[rtl/core/command_frame_receiver.sv]
// Command frame receiver: a request is taken into the input register; when the output
// slot is free, its result (if any) is registered in the output register.
// Throughput is one request per cycle; only a stalled result holds back the input.
// Reset is synchronous: configuration returns to its defaults (timeout of 1000
// ticks, checksum off, seed zero) and the receiver hunts for a preamble.
`timescale 1ns / 1ps

module command_frame_receiver
   import cfr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic [7:0]                req_rx_byte,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_kind,
   output logic [6:0]                rsp_command_id,
   output logic [7:0]                rsp_payload_length,
   output logic [7:0]                rsp_byte_index,
   output logic [7:0]                rsp_data_byte,

   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type    cfg;
   result_type result;

   // Input register: holds one request until the frame logic has consumed it.
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_action_ff;
   logic [7:0] in_byte_ff;

   // Output register: holds one result until the receiver takes it.
   logic       out_valid_ff, out_valid_in;
   logic [2:0] out_kind_ff;
   logic [6:0] out_command_id_ff;
   logic [7:0] out_payload_length_ff;
   logic [7:0] out_byte_index_ff;
   logic [7:0] out_data_byte_ff;

   logic       out_free;
   logic       step;
   logic       in_load;

   // The frame logic steps when the output slot is empty or is emptied in this
   // cycle, so a request is only processed when its result has somewhere to go.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_load   = req_valid && !req_stall;

   cfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cfr_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .action  (in_action_ff),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // The input register empties when it steps and refills from the port.
   assign in_valid_in = in_load || (in_valid_ff && !step);

   // A result that has been taken is replaced by the next one, if any; a
   // request that yields nothing leaves the output slot empty.
   always_comb begin
      if (step) begin
         out_valid_in = result.valid;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid) begin
         out_kind_ff           <= 3'(result.kind);
         out_command_id_ff     <= result.command_id;
         out_payload_length_ff <= result.payload_length;
         out_byte_index_ff     <= result.byte_index;
         out_data_byte_ff      <= result.data_byte;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_command_id     = out_command_id_ff;
   assign rsp_payload_length = out_payload_length_ff;
   assign rsp_byte_index     = out_byte_index_ff;
   assign rsp_data_byte      = out_data_byte_ff;

endmodule
